// ===== design/dlt_pkg.sv =====
// Shared types and constants of the dense layer training engine.
// Depends on nothing; the top level and the testbench import it.
`timescale 1ns / 1ps

package dlt_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 12;
    localparam int VAL_W      = 16;
    localparam int CNT_W      = 7;
    localparam int LR_W       = 16;
    localparam int KIND_W     = 2;
    localparam int POS_W      = 6;
    localparam int GACC_W     = 32;
    localparam int ACC_W      = 38;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WR_WEIGHT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_BIAS   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FWD_ELEM  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_IN   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GRAD_ELEM = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UPDATE    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RD_WEIGHT = 3'd7;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_FWD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WREAD = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd2;

    // Register reset values.
    localparam logic [CNT_W-1:0] IN_COUNT_RST   = 7'd64;
    localparam logic [CNT_W-1:0] OUT_COUNT_RST  = 7'd64;
    localparam logic [LR_W-1:0]  LEARN_RATE_RST = 16'd655;

    // Kinds of pass run by the sequencer.
    localparam logic [1:0] MODE_FWD  = 2'd0;
    localparam logic [1:0] MODE_GRAD = 2'd1;
    localparam logic [1:0] MODE_UPD  = 2'd2;

    // Tags that travel with each issued memory access.
    typedef struct packed {
        logic [1:0]       mode;
        logic             first;
        logic             last;
        logic             run_last;
        logic             gb_en;
        logic [POS_W-1:0] pos;
    } t_tag;

endpackage

// ===== design/dlt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module dlt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dense_layer_train_engine.sv =====
// Top level of the dense layer training engine: sequencer, MAC pipeline, memories.
// Depends on dlt_pkg and dlt_ram.
//
//  Channel   Direction  Ports                                        Handshake
//  command   in         i_command, i_index, i_value, i_row_last       start && !busy
//  result    out        o_kind, o_position, o_result, o_run_end       o_strobe, one cycle
//  config    in         i_cfg_index, i_cfg_data                       i_cfg_we
//
// A forward or gradient row end and an update walk in_count*out_count weights, one weight per
// cycle through the weight memory port. A clear walks all IN_MAX*OUT_MAX gradient entries; a
// clearing pass also runs after reset, with busy high. A weight read runs a bit-serial modulo
// to find the column. The receiver cannot stall the results.
`timescale 1ns / 1ps

module dense_layer_train_engine import dlt_pkg::*; #(
    parameter int IN_MAX    = 64,
    parameter int OUT_MAX   = 64,
    parameter int FRAC_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [IDX_W-1:0]       i_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                   i_row_last,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output logic [KIND_W-1:0]      o_kind,
    output logic [POS_W-1:0]       o_position,
    output logic signed [VAL_W-1:0] o_result,
    output logic                   o_run_end
);

    localparam int W_DEPTH = IN_MAX * OUT_MAX;
    localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int IN_AW   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int OUT_AW  = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int UP_W    = 49;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CLR  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_MOD  = 2'd3;

    function automatic logic [VAL_W-1:0] sat16(input logic signed [UP_W-1:0] v);
        logic [VAL_W-1:0] res;
        if (v > UP_W'(32767)) begin
            res = 16'h7FFF;
        end else if (v < -UP_W'(32768)) begin
            res = 16'h8000;
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [GACC_W-1:0] sat32(input logic signed [GACC_W:0] v);
        logic [GACC_W-1:0] res;
        if (v[GACC_W] != v[GACC_W-1]) begin
            res = v[GACC_W] ? {1'b1, {(GACC_W-1){1'b0}}} : {1'b0, {(GACC_W-1){1'b1}}};
        end else begin
            res = v[GACC_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [CNT_W-1:0] r_in_count;
    logic [CNT_W-1:0] r_out_count;
    logic [LR_W-1:0]  r_learn_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count   <= IN_COUNT_RST;
            r_out_count  <= OUT_COUNT_RST;
            r_learn_rate <= LEARN_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IN_COUNT:   r_in_count   <= i_cfg_data[CNT_W-1:0];
                CFG_OUT_COUNT:  r_out_count  <= i_cfg_data[CNT_W-1:0];
                CFG_LEARN_RATE: r_learn_rate <= i_cfg_data[LR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective counts: zero is taken as one, and counts are clamped to the sizes built.
    logic [CNT_W-1:0] ic, oc, ic_m1, oc_m1;
    assign ic = (r_in_count == '0) ? CNT_W'(1) :
                (r_in_count > CNT_W'(IN_MAX)) ? CNT_W'(IN_MAX) : r_in_count;
    assign oc = (r_out_count == '0) ? CNT_W'(1) :
                (r_out_count > CNT_W'(OUT_MAX)) ? CNT_W'(OUT_MAX) : r_out_count;
    assign ic_m1 = ic - CNT_W'(1);
    assign oc_m1 = oc - CNT_W'(1);

    // Sequencer state.
    logic [1:0]        r_state;
    logic [1:0]        r_mode;
    logic [IN_AW-1:0]  r_r;
    logic [OUT_AW-1:0] r_c;
    logic [W_AW-1:0]   r_addr;
    logic [IDX_W-1:0]  r_idx;
    logic              r_oob;
    logic [POS_W-1:0]  r_rem;
    logic [3:0]        r_bit;

    logic r_p1_v, r_p2_v, r_p3_v;
    logic accept;
    assign busy   = (r_state != S_IDLE) || r_p1_v || r_p2_v || r_p3_v;
    assign accept = start && !busy;

    // Position of the current access within the pass.
    logic r_is_last, c_is_last, iss_v;
    t_tag iss_tag;
    assign r_is_last = (CNT_W'(r_r) == ic_m1);
    assign c_is_last = (CNT_W'(r_c) == oc_m1);
    assign iss_v     = (r_state == S_RUN);

    always_comb begin
        iss_tag          = '0;
        iss_tag.mode     = r_mode;
        iss_tag.run_last = r_is_last && c_is_last;
        case (r_mode)
            MODE_FWD: begin
                iss_tag.first = (r_r == '0);
                iss_tag.last  = r_is_last;
                iss_tag.pos   = POS_W'(r_c);
            end
            MODE_GRAD: begin
                iss_tag.first = (r_c == '0);
                iss_tag.last  = c_is_last;
                iss_tag.gb_en = (r_r == '0);
                iss_tag.pos   = POS_W'(r_r);
            end
            default: begin
                iss_tag.gb_en = (r_r == '0);
                iss_tag.pos   = POS_W'(r_c);
            end
        endcase
    end

    // Bit-serial remainder of the weight index by the column count.
    logic [CNT_W-1:0] rem_try;
    logic [POS_W-1:0] rem_next;
    assign rem_try  = {r_rem, r_idx[IDX_W-1]};
    assign rem_next = (rem_try >= oc) ? POS_W'(rem_try - oc) : POS_W'(rem_try);

    // Sequencer: starts passes, walks the address counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_mode  <= MODE_FWD;
            r_r     <= '0;
            r_c     <= '0;
            r_addr  <= '0;
            r_rem   <= '0;
            r_bit   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_command)
                            CMD_FWD_ELEM: begin
                                if (i_row_last) begin
                                    r_state <= S_RUN;
                                    r_mode  <= MODE_FWD;
                                    r_r     <= '0;
                                    r_c     <= '0;
                                    r_addr  <= '0;
                                end
                            end
                            CMD_GRAD_ELEM: begin
                                if (i_row_last) begin
                                    r_state <= S_RUN;
                                    r_mode  <= MODE_GRAD;
                                    r_r     <= '0;
                                    r_c     <= '0;
                                    r_addr  <= '0;
                                end
                            end
                            CMD_UPDATE: begin
                                r_state <= S_RUN;
                                r_mode  <= MODE_UPD;
                                r_r     <= '0;
                                r_c     <= '0;
                                r_addr  <= '0;
                            end
                            CMD_CLEAR: begin
                                r_state <= S_CLR;
                                r_addr  <= '0;
                            end
                            CMD_RD_WEIGHT: begin
                                r_state <= S_MOD;
                                r_addr  <= i_index[W_AW-1:0];
                                r_rem   <= '0;
                                r_bit   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_addr == W_AW'(W_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                        r_addr  <= '0;
                    end else begin
                        r_addr <= r_addr + W_AW'(1);
                    end
                end
                S_RUN: begin
                    if (r_is_last && c_is_last) begin
                        r_state <= S_IDLE;
                    end
                    if (r_mode == MODE_FWD) begin
                        // Column-major walk: the weight address steps by the row pitch.
                        if (r_is_last) begin
                            r_r    <= '0;
                            r_c    <= r_c + OUT_AW'(1);
                            r_addr <= W_AW'(r_c) + W_AW'(1);
                        end else begin
                            r_r    <= r_r + IN_AW'(1);
                            r_addr <= r_addr + W_AW'(oc);
                        end
                    end else begin
                        if (c_is_last) begin
                            r_c <= '0;
                            r_r <= r_r + IN_AW'(1);
                        end else begin
                            r_c <= r_c + OUT_AW'(1);
                        end
                        r_addr <= r_addr + W_AW'(1);
                    end
                end
                S_MOD: begin
                    r_rem <= rem_next;
                    r_bit <= r_bit + 4'd1;
                    if (r_bit == 4'(IDX_W - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Index of a weight read; shifted out one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (accept && (i_command == CMD_RD_WEIGHT)) begin
            r_idx <= i_index;
            r_oob <= !(int'(i_index) < W_DEPTH);
        end else if (r_state == S_MOD) begin
            r_idx <= {r_idx[IDX_W-2:0], 1'b0};
        end
    end

    // Memory read data.
    logic [VAL_W-1:0]  w_rd, b_rd, x_rd, dy_rd;
    logic [GACC_W-1:0] gw_rd, gb_rd;

    // Pipeline stage 1: memory data arrives; the products are formed.
    t_tag              r_p1_tag, r_p2_tag;
    logic [W_AW-1:0]   r_p1_addr, r_p2_addr;
    logic [OUT_AW-1:0] r_p1_c, r_p2_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= iss_v;
        end
        r_p1_tag  <= iss_tag;
        r_p1_addr <= r_addr;
        r_p1_c    <= r_c;
    end

    logic signed [VAL_W-1:0]    mul_lhs;
    logic signed [2*VAL_W-1:0]  n_ma, n_mb;
    logic signed [UP_W-1:0]     n_mu, n_mub;
    assign mul_lhs = (r_p1_tag.mode == MODE_FWD) ? $signed(x_rd) : $signed(dy_rd);
    assign n_ma    = mul_lhs * $signed(w_rd);
    assign n_mb    = $signed(x_rd) * $signed(dy_rd);
    assign n_mu    = $signed({1'b0, r_learn_rate}) * $signed(gw_rd);
    assign n_mub   = $signed({1'b0, r_learn_rate}) * $signed(gb_rd);

    // Pipeline stage 2: accumulate, and write back gradients or weights and biases.
    logic signed [2*VAL_W-1:0] r_p2_ma, r_p2_mb;
    logic signed [UP_W-1:0]    r_p2_mu, r_p2_mub;
    logic signed [VAL_W-1:0]   r_p2_w, r_p2_b, r_p2_dy;
    logic signed [GACC_W-1:0]  r_p2_gw, r_p2_gb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else begin
            r_p2_v <= r_p1_v;
        end
        r_p2_tag  <= r_p1_tag;
        r_p2_addr <= r_p1_addr;
        r_p2_c    <= r_p1_c;
        r_p2_ma   <= n_ma;
        r_p2_mb   <= n_mb;
        r_p2_mu   <= n_mu;
        r_p2_mub  <= n_mub;
        r_p2_w    <= $signed(w_rd);
        r_p2_b    <= $signed(b_rd);
        r_p2_dy   <= $signed(dy_rd);
        r_p2_gw   <= $signed(gw_rd);
        r_p2_gb   <= $signed(gb_rd);
    end

    logic signed [ACC_W-1:0]  r_acc, acc_next, ma_ext;
    logic signed [GACC_W:0]   gw_sum, gb_sum;
    logic signed [UP_W-1:0]   d_w, d_b, w_diff, b_diff;
    logic [GACC_W-1:0]        gw_new, gb_new;
    logic [VAL_W-1:0]         w_new, b_new;
    logic                     p2_upd, p2_grad, p2_mac;

    assign p2_upd  = r_p2_v && (r_p2_tag.mode == MODE_UPD);
    assign p2_grad = r_p2_v && (r_p2_tag.mode == MODE_GRAD);
    assign p2_mac  = r_p2_v && (r_p2_tag.mode != MODE_UPD);

    assign ma_ext   = ACC_W'(r_p2_ma);
    assign acc_next = r_p2_tag.first ? ma_ext : r_acc + ma_ext;
    assign gw_sum   = (GACC_W+1)'(r_p2_gw) + (GACC_W+1)'(r_p2_mb);
    assign gb_sum   = (GACC_W+1)'(r_p2_gb) + ((GACC_W+1)'(r_p2_dy) <<< FRAC_BITS);
    assign gw_new   = sat32(gw_sum);
    assign gb_new   = sat32(gb_sum);

    // SGD step: round half up at 16 + FRAC_BITS fraction bits, then subtract.
    assign d_w    = (r_p2_mu + (UP_W'(1) <<< (LR_W + FRAC_BITS - 1))) >>> (LR_W + FRAC_BITS);
    assign d_b    = (r_p2_mub + (UP_W'(1) <<< (LR_W + FRAC_BITS - 1))) >>> (LR_W + FRAC_BITS);
    assign w_diff = UP_W'(r_p2_w) - d_w;
    assign b_diff = UP_W'(r_p2_b) - d_b;
    assign w_new  = sat16(w_diff);
    assign b_new  = sat16(b_diff);

    always_ff @(posedge i_clk) begin
        if (p2_mac) begin
            r_acc <= acc_next;
        end
    end

    // Pipeline stage 3: round a finished sum and add the bias in forward passes.
    logic signed [ACC_W-1:0] r_p3_acc;
    logic signed [VAL_W-1:0] r_p3_bias;
    logic [POS_W-1:0]        r_p3_pos;
    logic                    r_p3_run_last;
    logic [KIND_W-1:0]       r_p3_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else begin
            r_p3_v <= p2_mac && r_p2_tag.last;
        end
        r_p3_acc      <= acc_next;
        r_p3_bias     <= (r_p2_tag.mode == MODE_FWD) ? r_p2_b : '0;
        r_p3_pos      <= r_p2_tag.pos;
        r_p3_run_last <= r_p2_tag.run_last;
        r_p3_kind     <= (r_p2_tag.mode == MODE_FWD) ? KIND_FWD : KIND_GRAD;
    end

    logic signed [UP_W-1:0] fin_sum;
    assign fin_sum = ((UP_W'(r_p3_acc) + (UP_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS)
                     + UP_W'(r_p3_bias);

    // Output word register.
    logic              r_o_strobe, r_o_run_end;
    logic [KIND_W-1:0] r_o_kind;
    logic [POS_W-1:0]  r_o_position;
    logic [VAL_W-1:0]  r_o_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= r_p3_v || ((r_state == S_MOD) && (r_bit == 4'(IDX_W - 1)));
        end
        if (r_p3_v) begin
            r_o_kind     <= r_p3_kind;
            r_o_position <= r_p3_pos;
            r_o_result   <= sat16(fin_sum);
            r_o_run_end  <= r_p3_run_last;
        end else begin
            r_o_kind     <= KIND_WREAD;
            r_o_position <= rem_next;
            r_o_result   <= r_oob ? '0 : w_rd;
            r_o_run_end  <= 1'b1;
        end
    end

    assign o_strobe   = r_o_strobe;
    assign o_kind     = r_o_kind;
    assign o_position = r_o_position;
    assign o_result   = $signed(r_o_result);
    assign o_run_end  = r_o_run_end;

    // Memory write controls.
    logic              cmd_w_we, cmd_b_we, cmd_x_we, cmd_dy_we, clr_act;
    logic              w_we, b_we, gw_we, gb_we;
    logic [W_AW-1:0]   w_waddr, gw_waddr;
    logic [OUT_AW-1:0] b_waddr, gb_waddr;
    logic [VAL_W-1:0]  w_wdata, b_wdata;
    logic [GACC_W-1:0] gw_wdata, gb_wdata;

    assign cmd_w_we  = accept && (i_command == CMD_WR_WEIGHT) && (int'(i_index) < W_DEPTH);
    assign cmd_b_we  = accept && (i_command == CMD_WR_BIAS) && (int'(i_index) < OUT_MAX);
    assign cmd_x_we  = accept && ((i_command == CMD_FWD_ELEM) || (i_command == CMD_LOAD_IN))
                       && (int'(i_index) < IN_MAX);
    assign cmd_dy_we = accept && (i_command == CMD_GRAD_ELEM) && (int'(i_index) < OUT_MAX);
    assign clr_act   = (r_state == S_CLR);

    assign w_we     = cmd_w_we || p2_upd;
    assign w_waddr  = p2_upd ? r_p2_addr : i_index[W_AW-1:0];
    assign w_wdata  = p2_upd ? w_new : i_value;
    assign b_we     = cmd_b_we || (p2_upd && r_p2_tag.gb_en);
    assign b_waddr  = p2_upd ? r_p2_c : i_index[OUT_AW-1:0];
    assign b_wdata  = p2_upd ? b_new : i_value;
    assign gw_we    = clr_act || p2_grad;
    assign gw_waddr = clr_act ? r_addr : r_p2_addr;
    assign gw_wdata = clr_act ? '0 : gw_new;
    assign gb_we    = (clr_act && (int'(r_addr) < OUT_MAX)) || (p2_grad && r_p2_tag.gb_en);
    assign gb_waddr = clr_act ? r_addr[OUT_AW-1:0] : r_p2_c;
    assign gb_wdata = clr_act ? '0 : gb_new;

    dlt_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_weight (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_addr), .o_rdata(w_rd)
    );

    dlt_ram #(.WIDTH(VAL_W), .DEPTH(OUT_MAX)) u_bias (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(r_c), .o_rdata(b_rd)
    );

    dlt_ram #(.WIDTH(GACC_W), .DEPTH(W_DEPTH)) u_grad_weight (
        .i_clk(i_clk), .i_we(gw_we), .i_waddr(gw_waddr), .i_wdata(gw_wdata),
        .i_raddr(r_addr), .o_rdata(gw_rd)
    );

    dlt_ram #(.WIDTH(GACC_W), .DEPTH(OUT_MAX)) u_grad_bias (
        .i_clk(i_clk), .i_we(gb_we), .i_waddr(gb_waddr), .i_wdata(gb_wdata),
        .i_raddr(r_c), .o_rdata(gb_rd)
    );

    dlt_ram #(.WIDTH(VAL_W), .DEPTH(IN_MAX)) u_input_row (
        .i_clk(i_clk), .i_we(cmd_x_we), .i_waddr(i_index[IN_AW-1:0]), .i_wdata(i_value),
        .i_raddr(r_r), .o_rdata(x_rd)
    );

    dlt_ram #(.WIDTH(VAL_W), .DEPTH(OUT_MAX)) u_grad_row (
        .i_clk(i_clk), .i_we(cmd_dy_we), .i_waddr(i_index[OUT_AW-1:0]), .i_wdata(i_value),
        .i_raddr(r_c), .o_rdata(dy_rd)
    );

    // Checks on the sequencer and the output word.
    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without work in progress");

    a_run_end_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_WREAD) |-> o_run_end)
        else $error("run end marker misplaced");

    a_fwd_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_FWD) |-> ({1'b0, o_position} < oc))
        else $error("forward result beyond the columns in use");

    a_grad_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_GRAD) |-> ({1'b0, o_position} < ic))
        else $error("input gradient beyond the features in use");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_act |-> !p2_grad && !cmd_w_we)
        else $error("gradient clear overlaps another write");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the dense layer training engine.
// Depends on dlt_pkg and dense_layer_train_engine; a built-in layer predictor checks every word.
`timescale 1ns / 1ps

module testbench;
    import dlt_pkg::*;

    localparam int NMAX   = 64;
    localparam int WDEPTH = NMAX * NMAX;
    localparam int FRAC   = 12;
    localparam int SETTLE = 4200;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
        logic                    last;
        bit                      typed;
        logic [KIND_W-1:0]       t_kind;
        logic [POS_W-1:0]        t_pos;
        logic signed [VAL_W-1:0] t_res;
    } t_layer_cmd;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] res;
        logic                    run_end;
    } t_layer_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CMD_W-1:0]        i_command = CMD_WR_WEIGHT;
    logic [IDX_W-1:0]        i_index = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    i_row_last = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_IN_COUNT;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    o_strobe;
    logic [KIND_W-1:0]       o_kind;
    logic [POS_W-1:0]        o_position;
    logic signed [VAL_W-1:0] o_result;
    logic                    o_run_end;

    dense_layer_train_engine dut (.*);

    // Predictor copy of the layer state and registers.
    logic signed [VAL_W-1:0] wt_mem [WDEPTH];
    logic signed [VAL_W-1:0] bias_mem [NMAX];
    logic signed [VAL_W-1:0] x_mem [NMAX];
    logic signed [VAL_W-1:0] dy_mem [NMAX];
    int                      gw_mem [WDEPTH];
    int                      gb_mem [NMAX];
    logic [CNT_W-1:0]        in_cnt = IN_COUNT_RST;
    logic [CNT_W-1:0]        out_cnt = OUT_COUNT_RST;
    logic [LR_W-1:0]         lr_val = LEARN_RATE_RST;

    // Which entries have been written, tracked when commands are queued.
    bit wt_ok [WDEPTH];
    bit bias_ok [NMAX];
    bit x_ok [NMAX];
    bit dy_ok [NMAX];

    t_layer_cmd  cmd_q [$];
    t_layer_word word_q [$];
    bit          drv_active = 1'b0;
    int          n_items = 0;
    int          n_words = 0;
    int          n_errors = 0;
    int          n_phases = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("Timeout with %0d words still expected", word_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int eff_count(logic [CNT_W-1:0] v);
        if (v < 1) return 1;
        if (v > NMAX) return NMAX;
        return int'(v);
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[VAL_W-1:0];
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Apply one accepted command to the predictor and queue the words it causes.
    function automatic void layer_predict(t_layer_cmd it);
        int     ic;
        int     oc;
        longint acc;
        int     k;
        ic = eff_count(in_cnt);
        oc = eff_count(out_cnt);
        case (it.cmd)
            CMD_WR_WEIGHT: wt_mem[it.idx] = it.val;
            CMD_WR_BIAS:   if (it.idx < NMAX) bias_mem[it.idx] = it.val;
            CMD_LOAD_IN:   if (it.idx < NMAX) x_mem[it.idx] = it.val;
            CMD_FWD_ELEM: begin
                if (it.idx < NMAX) x_mem[it.idx] = it.val;
                if (it.last) begin
                    for (int c = 0; c < oc; c++) begin
                        acc = 0;
                        for (int r = 0; r < ic; r++)
                            acc += longint'(x_mem[r]) * longint'(wt_mem[r * oc + c]);
                        acc = round_shift(acc, FRAC) + longint'(bias_mem[c]);
                        word_q.push_back('{KIND_FWD, c[POS_W-1:0], sat16(acc), c + 1 == oc});
                    end
                end
            end
            CMD_GRAD_ELEM: begin
                if (it.idx < NMAX) dy_mem[it.idx] = it.val;
                if (it.last) begin
                    for (int r = 0; r < ic; r++) begin
                        acc = 0;
                        for (int c = 0; c < oc; c++)
                            acc += longint'(dy_mem[c]) * longint'(wt_mem[r * oc + c]);
                        word_q.push_back('{KIND_GRAD, r[POS_W-1:0],
                                           sat16(round_shift(acc, FRAC)), r + 1 == ic});
                    end
                    for (int r = 0; r < ic; r++)
                        for (int c = 0; c < oc; c++) begin
                            k = r * oc + c;
                            gw_mem[k] = sat32(longint'(gw_mem[k])
                                              + longint'(x_mem[r]) * longint'(dy_mem[c]));
                        end
                    for (int c = 0; c < oc; c++)
                        gb_mem[c] = sat32(longint'(gb_mem[c]) + (longint'(dy_mem[c]) <<< FRAC));
                end
            end
            CMD_CLEAR: begin
                foreach (gw_mem[i]) gw_mem[i] = 0;
                foreach (gb_mem[i]) gb_mem[i] = 0;
            end
            CMD_UPDATE: begin
                for (int i = 0; i < ic * oc; i++)
                    wt_mem[i] = sat16(longint'(wt_mem[i])
                        - round_shift(longint'(lr_val) * longint'(gw_mem[i]), LR_W + FRAC));
                for (int c = 0; c < oc; c++)
                    bias_mem[c] = sat16(longint'(bias_mem[c])
                        - round_shift(longint'(lr_val) * longint'(gb_mem[c]), LR_W + FRAC));
            end
            default: begin
                k = int'(it.idx) % oc;
                if (it.typed)
                    word_q.push_back('{it.t_kind, it.t_pos, it.t_res, 1'b1});
                else
                    word_q.push_back('{KIND_WREAD, k[POS_W-1:0], wt_mem[it.idx], 1'b1});
            end
        endcase
    endfunction

    // Queue a command and note which stores it fills.
    function automatic void enqueue(t_layer_cmd it);
        case (it.cmd)
            CMD_WR_WEIGHT: wt_ok[it.idx] = 1'b1;
            CMD_WR_BIAS:   if (it.idx < NMAX) bias_ok[it.idx] = 1'b1;
            CMD_LOAD_IN, CMD_FWD_ELEM: if (it.idx < NMAX) x_ok[it.idx] = 1'b1;
            CMD_GRAD_ELEM: if (it.idx < NMAX) dy_ok[it.idx] = 1'b1;
            default: ;
        endcase
        cmd_q.push_back(it);
    endfunction

    function automatic void put(logic [CMD_W-1:0] cmd, int idx, logic signed [VAL_W-1:0] val,
                                bit last);
        t_layer_cmd it;
        it = '{cmd, idx[IDX_W-1:0], val, last, 1'b0, KIND_FWD, '0, '0};
        enqueue(it);
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return $urandom_range(0, 8191) - 4096;
        endcase
    endfunction

    // Command driver: one word per accepted start, random gaps between words.
    initial begin
        t_layer_cmd it;
        int         gap;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            if (cmd_q.size() == 0) begin
                start <= 1'b0;
                @(posedge i_clk);
            end else begin
                drv_active = 1'b1;
                it = cmd_q.pop_front();
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 4) == 0) gap = 0;
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                start      <= 1'b1;
                i_command  <= it.cmd;
                i_index    <= it.idx;
                i_value    <= it.val;
                i_row_last <= it.last;
                // Busy only moves at a rising edge, so mid-cycle tells the next edge.
                forever begin
                    @(negedge i_clk);
                    if (!busy) break;
                end
                @(posedge i_clk);
                layer_predict(it);
                n_items++;
                drv_active = 1'b0;
            end
        end
    end

    // Result checker: a word is valid for the whole strobe cycle.
    always @(negedge i_clk) begin
        t_layer_word e;
        if (i_rst_n && o_strobe) begin
            n_words++;
            if (word_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Unexpected word kind %0d pos %0d result %0d end %0b",
                             o_kind, o_position, o_result, o_run_end);
            end else begin
                e = word_q.pop_front();
                if (o_kind !== e.kind || o_position !== e.pos || o_result !== e.res
                    || o_run_end !== e.run_end) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("Mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 e.kind, e.pos, e.res, e.run_end,
                                 o_kind, o_position, o_result, o_run_end);
                end
            end
        end
    end

    // Wait until every queued word has gone and the engine has finished any silent run.
    task automatic settle();
        while (cmd_q.size() != 0 || drv_active || word_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IN_COUNT:  in_cnt = data[CNT_W-1:0];
            CFG_OUT_COUNT: out_cnt = data[CNT_W-1:0];
            default:       lr_val = data;
        endcase
    endtask

    task automatic set_layer(int n_in, int n_out, int lr);
        logic [8:0] junk;
        junk = $urandom;
        cfg_write(CFG_IN_COUNT, {junk, n_in[CNT_W-1:0]});
        junk = $urandom;
        cfg_write(CFG_OUT_COUNT, {junk, n_out[CNT_W-1:0]});
        cfg_write(CFG_LEARN_RATE, lr[LR_W-1:0]);
        n_phases++;
    endtask

    // Write every entry the current shape reads that has not been written yet.
    task automatic fill_stores();
        int ic;
        int oc;
        ic = eff_count(in_cnt);
        oc = eff_count(out_cnt);
        for (int i = 0; i < ic * oc; i++) if (!wt_ok[i]) put(CMD_WR_WEIGHT, i, rand_value(), 0);
        for (int c = 0; c < oc; c++) if (!bias_ok[c]) put(CMD_WR_BIAS, c, rand_value(), 0);
        for (int r = 0; r < ic; r++) if (!x_ok[r]) put(CMD_LOAD_IN, r, rand_value(), 0);
        for (int c = 0; c < oc; c++) if (!dy_ok[c]) put(CMD_GRAD_ELEM, c, rand_value(), 0);
    endtask

    function automatic int pick_index(int lim);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
        return $urandom_range(0, lim - 1);
    endfunction

    // Random traffic: loose commands of every kind, plus some whole rows with random content.
    task automatic random_traffic(int n);
        int ic;
        int oc;
        int sel;
        int k;
        ic = eff_count(in_cnt);
        oc = eff_count(out_cnt);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) put(CMD_WR_WEIGHT, pick_index(ic * oc), rand_value(), 0);
            else if (sel < 18) put(CMD_WR_BIAS, pick_index(oc), rand_value(), 0);
            else if (sel < 26) put(CMD_LOAD_IN, pick_index(ic), rand_value(), 0);
            else if (sel < 40) begin
                if (ic <= 8 && $urandom_range(0, 1))
                    for (int r = 0; r < ic; r++) put(CMD_FWD_ELEM, r, rand_value(), r == ic - 1);
                else
                    put(CMD_FWD_ELEM, pick_index(ic), rand_value(), $urandom_range(0, 3) == 0);
            end else if (sel < 58) begin
                if (oc <= 9 && $urandom_range(0, 1))
                    for (int c = 0; c < oc; c++) put(CMD_GRAD_ELEM, c, rand_value(), c == oc - 1);
                else
                    put(CMD_GRAD_ELEM, pick_index(oc), rand_value(), $urandom_range(0, 3) == 0);
            end else if (sel < 61) put(CMD_CLEAR, $urandom_range(0, 4095), rand_value(), 0);
            else if (sel < 70) put(CMD_UPDATE, $urandom_range(0, 4095), rand_value(), 0);
            else begin
                k = pick_index(ic * oc);
                if (!wt_ok[k]) k = $urandom_range(0, ic * oc - 1);
                put(CMD_RD_WEIGHT, k, rand_value(), $urandom_range(0, 1));
            end
        end
    endtask

    // Directed rows, run with two inputs and three outputs.
    t_layer_cmd directed [] = '{
        '{CMD_WR_WEIGHT, 12'd0,    16'sh7FFF, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_WEIGHT, 12'd1,    16'sh8000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_WEIGHT, 12'd2,    16'sh0000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_WEIGHT, 12'd3,    16'sh1000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_WEIGHT, 12'd4,    16'shFFFF, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_WEIGHT, 12'd5,    16'sh0001, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_WEIGHT, 12'd4095, 16'sh5A5A, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_RD_WEIGHT, 12'd0,    16'sh0000, 1'b0, 1'b1, KIND_WREAD, 6'd0, 16'sh7FFF},
        '{CMD_RD_WEIGHT, 12'd1,    16'sh0000, 1'b0, 1'b1, KIND_WREAD, 6'd1, 16'sh8000},
        '{CMD_RD_WEIGHT, 12'd5,    16'sh0000, 1'b1, 1'b1, KIND_WREAD, 6'd2, 16'sh0001},
        '{CMD_RD_WEIGHT, 12'd4095, 16'sh0000, 1'b0, 1'b1, KIND_WREAD, 6'd0, 16'sh5A5A},
        '{CMD_WR_BIAS,   12'd0,    16'sh7FFF, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_BIAS,   12'd1,    16'sh8000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_BIAS,   12'd2,    16'sh0800, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_WR_BIAS,   12'd4095, 16'sh1234, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_LOAD_IN,   12'd0,    16'sh7FFF, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_LOAD_IN,   12'd100,  16'sh4321, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_FWD_ELEM,  12'd1,    16'sh8000, 1'b1, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_GRAD_ELEM, 12'd0,    16'sh1000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_GRAD_ELEM, 12'd1,    16'sh8000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_GRAD_ELEM, 12'd2,    16'sh7FFF, 1'b1, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_UPDATE,    12'd0,    16'sh0000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_RD_WEIGHT, 12'd3,    16'sh0000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_CLEAR,     12'd0,    16'sh0000, 1'b0, 1'b0, KIND_FWD,   6'd0, 16'sh0},
        '{CMD_FWD_ELEM,  12'd4000, 16'sh2222, 1'b1, 1'b0, KIND_FWD,   6'd0, 16'sh0}
    };

    // Layer shapes and step sizes of the random phases, extremes included.
    int shapes [][4] = '{
        '{1, 1, 0, 20}, '{0, 0, 65535, 15}, '{5, 7, 655, 30}, '{8, 3, 40000, 30},
        '{2, 9, 1, 25}, '{127, 1, 65535, 10}, '{3, 4, 300, 10}, '{6, 5, 12345, 25}
    };

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the clearing pass after reset finish before touching the registers.
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        set_layer(2, 3, 655);
        foreach (directed[i]) enqueue(directed[i]);
        settle();
        foreach (shapes[p]) begin
            set_layer(shapes[p][0], shapes[p][1], shapes[p][2]);
            fill_stores();
            random_traffic(shapes[p][3]);
            settle();
        end
        $display("Covered %0d commands in %0d layer shapes, %0d result words checked",
                 n_items, n_phases, n_words);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/dlt_pkg.sv
design/dlt_ram.sv
design/dense_layer_train_engine.sv
dv/testbench.sv
